// ===== rtl/sha256_byte_stream_hash_core_defines.svh =====
// Assertion helpers for the SHA-256 byte stream core.
// Both macros expect signals named clk and rst at the place of use.
`ifndef SHA256_BYTE_STREAM_HASH_CORE_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASH_CORE_DEFINES_SVH

// Same-cycle implication.
`define SHA256BSH_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define SHA256BSH_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/sha256bsh_pkg.sv =====
package sha256bsh_pkg;

  // Eight 32-bit working or chaining words, index 0 is a / h0.
  typedef logic [7:0][31:0] work_t;

  localparam work_t INIT_HASH = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  // Fill level at which the 64-bit length field starts.
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;

endpackage

// ===== rtl/sha256bsh_round.sv =====
// One SHA-256 round plus one message schedule step.
module sha256bsh_round (
  input  sha256bsh_pkg::work_t vars,
  input  logic [511:0]         window,
  input  logic [5:0]           rnd,
  output sha256bsh_pkg::work_t vars_next,
  output logic [511:0]         window_next
);

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  logic [31:0] w_t, w_1, w_9, w_14, w_new;
  logic [31:0] ch, maj, t1, t2;

  // Window holds w[t] .. w[t+15], oldest word at the top.
  assign w_t  = window[511:480];
  assign w_1  = window[479:448];
  assign w_9  = window[223:192];
  assign w_14 = window[63:32];
  assign w_new = small_sigma1(w_14) + w_9 + small_sigma0(w_1) + w_t;
  assign window_next = {window[479:0], w_new};

  assign ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1  = vars[7] + big_sigma1(vars[4]) + ch + sha256bsh_pkg::ROUND_K[rnd] + w_t;
  assign t2  = big_sigma0(vars[0]) + maj;

  assign vars_next = {vars[6], vars[5], vars[4], vars[3] + t1,
                      vars[2], vars[1], vars[0], t1 + t2};

endmodule

// ===== rtl/sha256_byte_stream_hash_core.sv =====
// SHA-256 over a byte stream. Send opcode 0 words to absorb one message byte each, then an
// opcode 1 word to finish: the core pads the message, runs the last one or two blocks and
// returns the digest as eight 32-bit words, h0 first, with last_word set on the eighth; it
// then starts a fresh message on its own. An absorb word just shifts its byte into the block
// buffer, except the 64th byte of a block, which also runs the compression: 64 rounds on
// the single shared round unit (one round per cycle) plus a feed-forward step. A finish
// word adds padding at one byte per cycle up to the length field, then the eight length
// bytes, one or two compressions and eight output words. item_stall is high for the whole
// time a word is being worked on. The message bit length wraps modulo 2^64.
`include "sha256_byte_stream_hash_core_defines.svh"

module sha256_byte_stream_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;  // take absorb or finish words
  localparam logic [2:0] ST_PAD   = 3'd1;  // shift in zero pad bytes
  localparam logic [2:0] ST_LEN   = 3'd2;  // shift in the bit length, high byte first
  localparam logic [2:0] ST_ROUND = 3'd3;  // 64 rounds on the shared round unit
  localparam logic [2:0] ST_FINAL = 3'd4;  // add working words into the chaining value
  localparam logic [2:0] ST_EMIT  = 3'd5;  // hand out the eight digest words

  localparam logic OP_ABSORB = 1'b0;

  logic [2:0]  state, state_next;
  logic [5:0]  fill, fill_next;
  logic [63:0] byte_count, byte_count_next;
  logic [5:0]  rnd;
  logic [2:0]  eidx;
  logic        finishing, finishing_next;
  logic        len_done, len_done_next;

  sha256bsh_pkg::work_t hash;
  sha256bsh_pkg::work_t vars;
  sha256bsh_pkg::work_t vars_round;

  // Block buffer, doubling as the message schedule window during the rounds.
  logic [511:0] block;
  logic [511:0] block_round;

  logic        shift_en;
  logic [7:0]  shift_byte;
  logic        item_take;
  logic        result_take;

  assign item_stall  = (state != ST_IDLE);
  assign item_take   = item_valid && !item_stall;
  assign result_valid = (state == ST_EMIT);
  assign result_take = result_valid && !result_stall;

  assign digest_word = hash[eidx];
  assign word_index  = eidx;
  assign last_word   = (eidx == 3'd7);

  sha256bsh_round u_round (
    .vars        (vars),
    .window      (block),
    .rnd         (rnd),
    .vars_next   (vars_round),
    .window_next (block_round)
  );

  // Sequencer: pick the next state and the byte shifted into the buffer.
  always_comb begin
    state_next      = state;
    fill_next       = fill;
    byte_count_next = byte_count;
    finishing_next  = finishing;
    len_done_next   = len_done;
    shift_en        = 1'b0;
    shift_byte      = 8'd0;
    unique case (state)
      ST_IDLE: begin
        if (item_take) begin
          shift_en  = 1'b1;
          fill_next = fill + 6'd1;
          if (opcode == OP_ABSORB) begin
            shift_byte      = data_byte;
            byte_count_next = byte_count + 64'd1;
          end else begin
            // Turn the byte count into the bit length and start padding.
            shift_byte      = sha256bsh_pkg::PAD_MARK;
            byte_count_next = {byte_count[60:0], 3'b000};
            finishing_next  = 1'b1;
            len_done_next   = 1'b0;
            state_next      = ST_PAD;
          end
          if (fill == sha256bsh_pkg::LAST_BYTE) begin
            state_next = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        if (fill == sha256bsh_pkg::LEN_POS) begin
          state_next = ST_LEN;
        end else begin
          shift_en  = 1'b1;
          fill_next = fill + 6'd1;
          if (fill == sha256bsh_pkg::LAST_BYTE) begin
            state_next = ST_ROUND;
          end
        end
      end
      ST_LEN: begin
        shift_en        = 1'b1;
        shift_byte      = byte_count[63:56];
        byte_count_next = {byte_count[55:0], 8'd0};
        fill_next       = fill + 6'd1;
        if (fill == sha256bsh_pkg::LAST_BYTE) begin
          len_done_next = 1'b1;
          state_next    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (len_done) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (result_take && last_word) begin
          // Rearm for the next message.
          byte_count_next = 64'd0;
          finishing_next  = 1'b0;
          len_done_next   = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= 6'd0;
      byte_count <= 64'd0;
      finishing  <= 1'b0;
      len_done   <= 1'b0;
      rnd        <= 6'd0;
      eidx       <= 3'd0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      byte_count <= byte_count_next;
      finishing  <= finishing_next;
      len_done   <= len_done_next;
      // Hold the round counter at zero outside the rounds.
      if (state == ST_ROUND) begin
        rnd <= rnd + 6'd1;
      end else begin
        rnd <= 6'd0;
      end
      if (state != ST_EMIT) begin
        eidx <= 3'd0;
      end else if (result_take) begin
        eidx <= eidx + 3'd1;
      end
    end
  end

  // Chaining value: feed-forward after each block, reload after the digest leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= sha256bsh_pkg::INIT_HASH;
    end else if (state == ST_FINAL) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + vars[i];
      end
    end else if (result_take && last_word) begin
      hash <= sha256bsh_pkg::INIT_HASH;
    end
  end

  // Payload: buffer shifts bytes in at the bottom, or words during the rounds.
  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      block <= block_round;
      vars  <= vars_round;
    end else begin
      if (shift_en) begin
        block <= {block[503:0], shift_byte};
      end
      // Keep the working words loaded from the chaining value until the rounds start.
      if (state != ST_FINAL) begin
        vars <= hash;
      end
    end
  end

  `SHA256BSH_ASSERT_NOW(a_emit_empty, state == ST_EMIT, fill == 6'd0 && finishing, "buffer not empty during digest output")
  `SHA256BSH_ASSERT_NEXT(a_round_to_final, state == ST_ROUND && rnd == 6'd63, state == ST_FINAL, "rounds did not end after 64 cycles")
  `SHA256BSH_ASSERT_NEXT(a_full_block, item_take && fill == sha256bsh_pkg::LAST_BYTE, state == ST_ROUND && rnd == 6'd0, "full block did not start compression")
  `SHA256BSH_ASSERT_NEXT(a_rearm, result_take && last_word, state == ST_IDLE && byte_count == 64'd0 && hash == sha256bsh_pkg::INIT_HASH, "core not rearmed after digest")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  // Opcodes of the input word.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Cycles with no handshake on either side before the run is declared hung.
  localparam int HANG_LIMIT = 4000;
  // Length of the one long receiver hold-off.
  localparam int LONG_HOLD = 400;
  // Pending words below which both sides stop idling.
  localparam int QUIET_TAIL = 30;

  // Standard initial chaining values, h0 first.
  localparam logic [31:0] SHA_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One word waiting to be sent; hold_for_drain keeps it back until every
  // digest word already owed has come out.
  typedef struct packed {
    logic       op;
    logic [7:0] msg_byte;
    logic       hold_for_drain;
  } send_word_t;

  // One digest word the core owes us.
  typedef struct packed {
    logic [31:0] hash_word;
    logic [2:0]  idx;
    logic        is_last;
  } digest_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        opcode = OP_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha256_byte_stream_hash_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  send_word_t   send_q [$];
  digest_word_t digest_q [$];

  // Our own copy of the hash state: chaining words, block buffer, fill level
  // and the running message byte count.
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  int          fill;
  logic [63:0] msg_len;

  int errors = 0;
  int words_in = 0;
  int finishes_in = 0;
  int digest_words_out = 0;
  int spill_blocks = 0;
  int hang_cnt = 0;

  // Driver and monitor bookkeeping.
  bit offer_taken = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int long_hold = 0;
  bit long_hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run the 64 rounds over blk and fold the result into the chaining words.
  function automatic void sha_compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, ch, maj, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    v = chain;
    for (int t = 0; t < 64; t++) begin
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1  = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch +
            SHA_K[t] + w[t];
      t2  = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + maj;
      for (int j = 7; j > 0; j--)
        v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain[i] = chain[i] + v[i];
    fill = 0;
  endfunction

  // Advance the hash state by one accepted word; a finish queues the eight
  // digest words and starts a fresh message.
  function automatic void sha_digest_step(logic op, logic [7:0] msg_byte);
    logic [63:0] bit_len;
    digest_word_t dw;
    if (op == OP_ABSORB) begin
      blk[fill] = msg_byte;
      fill++;
      msg_len++;
      if (fill == 64)
        sha_compress_block();
    end else begin
      blk[fill] = 8'h80;
      fill++;
      // No room left for the length field: close this block with zeros and
      // put the length in an extra one.
      if (fill > 56) begin
        while (fill < 64) begin
          blk[fill] = 8'h00;
          fill++;
        end
        sha_compress_block();
        spill_blocks++;
      end
      while (fill < 56) begin
        blk[fill] = 8'h00;
        fill++;
      end
      bit_len = msg_len << 3;
      for (int i = 0; i < 8; i++)
        blk[56+i] = bit_len[63-8*i -: 8];
      sha_compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.hash_word = chain[i];
        dw.idx       = 3'(i);
        dw.is_last   = (i == 7);
        digest_q.push_back(dw);
      end
      chain   = SHA_IV;
      fill    = 0;
      msg_len = '0;
    end
  endfunction

  // Input side: note the accepted word and predict what it causes.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      sha_digest_step(opcode, data_byte);
      void'(send_q.pop_front());
      offer_taken = 1'b1;
      words_in++;
      if (opcode == OP_FINISH)
        finishes_in++;
    end
  end

  // Driver: present the next pending word at the falling edge. Hold the word
  // steady while it waits, drop valid in random bursts, and keep back a word
  // marked for drain until the digest queue is empty.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !offer_taken) begin
      // hold: the current word has not been taken yet
    end else begin
      offer_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (send_q.size() == 0 ||
                   (send_q[0].hold_for_drain && digest_q.size() != 0)) begin
        item_valid <= 1'b0;
      end else if (send_q.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 9);
        item_valid <= 1'b0;
      end else begin
        item_valid <= 1'b1;
        opcode     <= send_q[0].op;
        data_byte  <= send_q[0].msg_byte;
      end
    end
  end

  // Output side: compare each accepted digest word against the oldest one owed.
  always @(posedge clk) begin
    digest_word_t dw;
    if (!rst && result_valid && !result_stall) begin
      digest_words_out++;
      if (digest_q.size() == 0) begin
        $display("%0t: digest word with none owed: word %h index %0d last %0b",
                 $time, digest_word, word_index, last_word);
        errors++;
      end else begin
        dw = digest_q.pop_front();
        if (digest_word !== dw.hash_word) begin
          $display("%0t: digest_word mismatch, expected %h, actual %h",
                   $time, dw.hash_word, digest_word);
          errors++;
        end
        if (word_index !== dw.idx) begin
          $display("%0t: word_index mismatch, expected %0d, actual %0d",
                   $time, dw.idx, word_index);
          errors++;
        end
        if (last_word !== dw.is_last) begin
          $display("%0t: last_word mismatch, expected %0b, actual %0b",
                   $time, dw.is_last, last_word);
          errors++;
        end
      end
    end
  end

  // Receiver stall: short random bursts, plus one long hold-off shortly after
  // the directed part so the core backs up into its input while the driver
  // keeps offering words.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold--;
      result_stall <= 1'b1;
    end else if (!long_hold_done && finishes_in >= 5) begin
      long_hold_done = 1'b1;
      long_hold = LONG_HOLD - 1;
      result_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      result_stall <= 1'b1;
    end else if (send_q.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 9);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      hang_cnt = 0;
    end else begin
      hang_cnt++;
      if (hang_cnt >= HANG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
        $display("** sha256_byte_stream_hash_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic add_word(logic op, logic [7:0] msg_byte, logic hold_for_drain);
    send_word_t sw;
    sw.op             = op;
    sw.msg_byte       = msg_byte;
    sw.hold_for_drain = hold_for_drain;
    send_q.push_back(sw);
  endtask

  // Queue a message of random bytes followed by its finish word.
  task automatic add_message(int len, logic hold_for_drain);
    for (int i = 0; i < len; i++)
      add_word(OP_ABSORB, 8'($urandom_range(0, 255)), (i == 0) && hold_for_drain);
    add_word(OP_FINISH, 8'($urandom_range(0, 255)), (len == 0) && hold_for_drain);
  endtask

  initial begin
    chain   = SHA_IV;
    fill    = 0;
    msg_len = '0;

    // Directed: empty message, back-to-back finishes, extreme data bytes,
    // and a finish whose data byte must be ignored.
    add_word(OP_FINISH, 8'h00, 1'b0);
    add_word(OP_FINISH, 8'hFF, 1'b0);
    add_word(OP_ABSORB, 8'h00, 1'b0);
    add_word(OP_ABSORB, 8'hFF, 1'b0);
    add_word(OP_ABSORB, 8'h80, 1'b0);
    add_word(OP_ABSORB, 8'h01, 1'b0);
    add_word(OP_FINISH, 8'hFF, 1'b0);
    add_word(OP_ABSORB, 8'h55, 1'b0);
    add_word(OP_ABSORB, 8'hAA, 1'b0);
    add_word(OP_FINISH, 8'h7F, 1'b0);
    add_word(OP_FINISH, 8'h00, 1'b0);

    // Block boundaries: length field just fits, padding spills into an extra
    // block, and a full block compressed on absorb before the finish.
    add_message(55, 1'b0);
    add_message(56, 1'b1);
    add_message(64, 1'b0);

    // Short random messages with stray finishes mixed in.
    while (send_q.size() < 215) begin
      if ($urandom_range(0, 9) == 0)
        add_word(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0);
      else
        add_message($urandom_range(0, 12), $urandom_range(0, 5) == 0);
    end
    // Leave a few bytes of an unfinished message at the end.
    for (int i = 0; i < 3; i++)
      add_word(OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (send_q.size() != 0 || digest_q.size() != 0)
      @(posedge clk);
    // Allow for a trailing block compression before declaring the core quiet.
    repeat (300) @(posedge clk);

    $display("Sent %0d words (%0d finishes, %0d with a spill block), checked %0d digest words.",
             words_in, finishes_in, spill_blocks, digest_words_out);
    $display("Messages ran from empty to a full 64-byte block, under random stalls on both sides.");
    if (errors == 0)
      $display("** sha256_byte_stream_hash_core: PASSED **");
    else
      $display("** sha256_byte_stream_hash_core: FAILED **");
    $finish;
  end

endmodule

// ===== sha256_byte_stream_hash_core.f =====
+incdir+rtl
rtl/sha256bsh_pkg.sv
rtl/sha256bsh_round.sv
rtl/sha256_byte_stream_hash_core.sv
dv/tb.sv
